// ----- hw/rtl/frwl_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// frwl_pkg
// Shared types and constants for the fair FIFO reader/writer lock manager.
// ----------------------------------------------------------------------------
package frwl_pkg;

  localparam int QUEUE_DEPTH_DEF = 16;
  localparam int MAX_READERS_DEF = 63;
  localparam int MAX_RESULTS     = 16;
  localparam int ID_W            = 4;
  localparam int CMD_W           = 2;
  localparam int STATUS_W        = 2;
  localparam int CMDQ_DEPTH      = 2;
  localparam int OUTQ_DEPTH      = 4;
  localparam int NRES_W          = $clog2(MAX_RESULTS + 1);

  typedef enum logic [CMD_W-1:0] {
    CMD_LOCK_RD   = 2'd0,
    CMD_LOCK_WR   = 2'd1,
    CMD_UNLOCK_RD = 2'd2,
    CMD_UNLOCK_WR = 2'd3
  } cmd_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_GRANT     = 2'd0,
    ST_NO_HOLDER = 2'd1,
    ST_FULL      = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_READ,
    S_EVAL,
    S_FLUSH
  } eng_state_t;

  // classified request handed from front to engine
  typedef struct packed {
    logic            lock;
    logic            write;
    logic [ID_W-1:0] id;
  } req_t;

  typedef struct packed {
    status_t         status;
    logic [ID_W-1:0] id;
    logic            write;
    logic            last;
  } result_t;

endpackage
`default_nettype wire

// ----- hw/rtl/frwl_front.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// frwl_front
// Accepts lock/unlock commands, classifies them and buffers them for the engine.
// ----------------------------------------------------------------------------
module frwl_front (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       push,
  output logic                            full,
  input  wire logic [frwl_pkg::CMD_W-1:0] cmd,
  input  wire logic [frwl_pkg::ID_W-1:0]  requester_id,
  output logic                            req_valid,
  output frwl_pkg::req_t                  req,
  input  wire logic                       req_take
);

  localparam int PTR_W = (frwl_pkg::CMDQ_DEPTH > 1) ? $clog2(frwl_pkg::CMDQ_DEPTH) : 1;
  localparam int CNT_W = $clog2(frwl_pkg::CMDQ_DEPTH + 1);

  frwl_pkg::req_t         buf_q [frwl_pkg::CMDQ_DEPTH];
  frwl_pkg::req_t         cls;
  logic [PTR_W-1:0]       wptr, rptr;
  logic [CNT_W-1:0]       count;
  logic                   do_wr, do_rd;

  always_comb begin
    cls.id = requester_id;
    case (frwl_pkg::cmd_t'(cmd))
      frwl_pkg::CMD_LOCK_RD:   begin cls.lock = 1'b1; cls.write = 1'b0; end
      frwl_pkg::CMD_LOCK_WR:   begin cls.lock = 1'b1; cls.write = 1'b1; end
      frwl_pkg::CMD_UNLOCK_RD: begin cls.lock = 1'b0; cls.write = 1'b0; end
      frwl_pkg::CMD_UNLOCK_WR: begin cls.lock = 1'b0; cls.write = 1'b1; end
      default:                 begin cls.lock = 1'b0; cls.write = 1'b0; end
    endcase
  end

  assign full      = (count == CNT_W'(frwl_pkg::CMDQ_DEPTH));
  assign req_valid = (count != '0);
  assign req       = buf_q[rptr];
  assign do_wr     = push && !full;
  assign do_rd     = req_take && req_valid;

  always_ff @(posedge clk) begin
    if (do_wr) begin
      buf_q[wptr] <= cls;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (do_wr) begin
        wptr <= (wptr == PTR_W'(frwl_pkg::CMDQ_DEPTH - 1)) ? '0 : wptr + 1'b1;
      end
      if (do_rd) begin
        rptr <= (rptr == PTR_W'(frwl_pkg::CMDQ_DEPTH - 1)) ? '0 : rptr + 1'b1;
      end
      if (do_wr && !do_rd) begin
        count <= count + 1'b1;
      end else if (do_rd && !do_wr) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule
`default_nettype wire

// ----- hw/rtl/frwl_engine.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// frwl_engine
// Carries out one request at a time: holds the wait queue and lock state and
// releases compatible heads of the queue, one grant per memory read.
// ----------------------------------------------------------------------------
module frwl_engine #(
  parameter int QUEUE_DEPTH = frwl_pkg::QUEUE_DEPTH_DEF,
  parameter int MAX_READERS = frwl_pkg::MAX_READERS_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        req_valid,
  input  wire frwl_pkg::req_t req,
  output logic             req_take,
  output logic             res_push,
  output frwl_pkg::result_t res,
  input  wire logic        res_full
);

  localparam int IDX_W   = $clog2(QUEUE_DEPTH);
  localparam int CNT_W   = $clog2(QUEUE_DEPTH + 1);
  localparam int SUM_W   = IDX_W + 1;
  localparam int RD_W    = $clog2(MAX_READERS + 1);
  localparam int ENTRY_W = frwl_pkg::ID_W + 1;

  frwl_pkg::eng_state_t   st, st_next;

  logic [ENTRY_W-1:0]     wq [QUEUE_DEPTH];
  logic [ENTRY_W-1:0]     rd_entry;
  logic                   wq_we, wq_re;
  logic [IDX_W-1:0]       wq_waddr;
  logic [SUM_W-1:0]       slot_sum;

  logic [CNT_W-1:0]       qcount, qcount_next;
  logic [IDX_W-1:0]       qhead, qhead_next;
  logic [RD_W-1:0]        readers, readers_next;
  logic                   writer, writer_next;
  logic                   pend_valid, pend_valid_next;
  frwl_pkg::result_t      pend, pend_next;
  logic [frwl_pkg::NRES_W-1:0] nres, nres_next;

  logic                   q_full, head_ok, drain_done, e_wr;

  assign slot_sum = SUM_W'(qhead) + SUM_W'(qcount);
  assign wq_waddr = (slot_sum >= SUM_W'(QUEUE_DEPTH)) ?
                    IDX_W'(slot_sum - SUM_W'(QUEUE_DEPTH)) : IDX_W'(slot_sum);

  assign q_full     = (qcount == CNT_W'(QUEUE_DEPTH));
  assign drain_done = (qcount == '0) || (nres == frwl_pkg::NRES_W'(frwl_pkg::MAX_RESULTS));
  assign e_wr       = rd_entry[ENTRY_W-1];
  assign head_ok    = !writer && (e_wr ? (readers == '0) : (readers != RD_W'(MAX_READERS)));

  // next state
  always_comb begin
    st_next = st;
    case (st)
      frwl_pkg::S_IDLE:  if (req_valid) st_next = frwl_pkg::S_READ;
      frwl_pkg::S_READ:  st_next = drain_done ? frwl_pkg::S_FLUSH : frwl_pkg::S_EVAL;
      frwl_pkg::S_EVAL: begin
        if (!head_ok) begin
          st_next = frwl_pkg::S_FLUSH;
        end else if (!(pend_valid && res_full)) begin
          st_next = frwl_pkg::S_READ;
        end
      end
      frwl_pkg::S_FLUSH: if (!pend_valid || !res_full) st_next = frwl_pkg::S_IDLE;
      default: st_next = frwl_pkg::S_IDLE;
    endcase
  end

  // outputs and datapath next values
  always_comb begin
    req_take        = 1'b0;
    res_push        = 1'b0;
    res             = pend;
    wq_we           = 1'b0;
    wq_re           = 1'b0;
    qcount_next     = qcount;
    qhead_next      = qhead;
    readers_next    = readers;
    writer_next     = writer;
    pend_valid_next = pend_valid;
    pend_next       = pend;
    nres_next       = nres;
    case (st)
      frwl_pkg::S_IDLE: begin
        if (req_valid) begin
          req_take        = 1'b1;
          pend_valid_next = 1'b0;
          nres_next       = '0;
          pend_next.id    = req.id;
          pend_next.write = req.write;
          pend_next.last  = 1'b0;
          pend_next.status = frwl_pkg::ST_NO_HOLDER;
          if (req.lock) begin
            if (q_full) begin
              pend_next.status = frwl_pkg::ST_FULL;
              pend_valid_next  = 1'b1;
              nres_next        = frwl_pkg::NRES_W'(1);
            end else begin
              wq_we       = 1'b1;
              qcount_next = qcount + 1'b1;
            end
          end else if (!req.write) begin
            if (readers == '0) begin
              pend_valid_next = 1'b1;
              nres_next       = frwl_pkg::NRES_W'(1);
            end else begin
              readers_next = readers - 1'b1;
            end
          end else begin
            if (!writer) begin
              pend_valid_next = 1'b1;
              nres_next       = frwl_pkg::NRES_W'(1);
            end else begin
              writer_next = 1'b0;
            end
          end
        end
      end
      frwl_pkg::S_READ: begin
        wq_re = !drain_done;
      end
      frwl_pkg::S_EVAL: begin
        if (head_ok && !(pend_valid && res_full)) begin
          // older pending result goes out now that a later one exists
          res_push         = pend_valid;
          res.last         = 1'b0;
          pend_valid_next  = 1'b1;
          pend_next.status = frwl_pkg::ST_GRANT;
          pend_next.id     = rd_entry[frwl_pkg::ID_W-1:0];
          pend_next.write  = e_wr;
          pend_next.last   = 1'b0;
          nres_next        = nres + 1'b1;
          qcount_next      = qcount - 1'b1;
          qhead_next       = (qhead == IDX_W'(QUEUE_DEPTH - 1)) ? '0 : qhead + 1'b1;
          if (e_wr) begin
            writer_next = 1'b1;
          end else begin
            readers_next = readers + 1'b1;
          end
        end
      end
      frwl_pkg::S_FLUSH: begin
        if (pend_valid && !res_full) begin
          res_push        = 1'b1;
          res.last        = 1'b1;
          pend_valid_next = 1'b0;
        end
      end
      default: begin
        pend_valid_next = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (wq_we) begin
      wq[wq_waddr] <= {req.write, req.id};
    end
    if (wq_re) begin
      rd_entry <= wq[qhead];
    end
  end

  always_ff @(posedge clk) begin
    pend <= pend_next;
    nres <= nres_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st         <= frwl_pkg::S_IDLE;
      qcount     <= '0;
      qhead      <= '0;
      readers    <= '0;
      writer     <= 1'b0;
      pend_valid <= 1'b0;
    end else begin
      st         <= st_next;
      qcount     <= qcount_next;
      qhead      <= qhead_next;
      readers    <= readers_next;
      writer     <= writer_next;
      pend_valid <= pend_valid_next;
    end
  end

endmodule
`default_nettype wire

// ----- hw/rtl/frwl_out_fifo.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// frwl_out_fifo
// Result queue between the engine and the consumer.
// ----------------------------------------------------------------------------
module frwl_out_fifo (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         push,
  input  wire frwl_pkg::result_t din,
  output logic              full,
  input  wire logic         pop,
  output frwl_pkg::result_t dout,
  output logic              empty
);

  localparam int PTR_W = $clog2(frwl_pkg::OUTQ_DEPTH);
  localparam int CNT_W = $clog2(frwl_pkg::OUTQ_DEPTH + 1);

  frwl_pkg::result_t  mem [frwl_pkg::OUTQ_DEPTH];
  logic [PTR_W-1:0]   wptr, rptr;
  logic [CNT_W-1:0]   count;
  logic               do_wr, do_rd;

  assign full  = (count == CNT_W'(frwl_pkg::OUTQ_DEPTH));
  assign empty = (count == '0);
  assign dout  = mem[rptr];
  assign do_wr = push && !full;
  assign do_rd = pop && !empty;

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem[wptr] <= din;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (do_wr) begin
        wptr <= (wptr == PTR_W'(frwl_pkg::OUTQ_DEPTH - 1)) ? '0 : wptr + 1'b1;
      end
      if (do_rd) begin
        rptr <= (rptr == PTR_W'(frwl_pkg::OUTQ_DEPTH - 1)) ? '0 : rptr + 1'b1;
      end
      if (do_wr && !do_rd) begin
        count <= count + 1'b1;
      end else if (do_rd && !do_wr) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule
`default_nettype wire

// ----- hw/rtl/fifo_fair_rw_lock_arbiter.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// fifo_fair_rw_lock_arbiter
// Fair FIFO reader/writer lock manager for one shared resource.
// ----------------------------------------------------------------------------
// Commands enter a two-entry command queue and are carried out one at a time
// by the lock engine. An unlock or lock that grants nothing still reads the
// head of a non-empty wait queue; every grant it releases goes through the
// registered read port of the wait-queue memory (address the head, then
// evaluate it). Results land in a four-entry result queue, so the consumer
// may stall without holding up command intake until that queue fills. The
// last result of each command that yields any carries last_of_run.
// No clearing pass is needed after reset.
module fifo_fair_rw_lock_arbiter #(
  parameter int QUEUE_DEPTH = frwl_pkg::QUEUE_DEPTH_DEF,
  parameter int MAX_READERS = frwl_pkg::MAX_READERS_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          push,
  output logic                               full,
  input  wire logic [frwl_pkg::CMD_W-1:0]    cmd,
  input  wire logic [frwl_pkg::ID_W-1:0]     requester_id,
  output logic                               empty,
  input  wire logic                          pop,
  output logic [frwl_pkg::STATUS_W-1:0]      status,
  output logic [frwl_pkg::ID_W-1:0]          granted_id,
  output logic                               granted_write,
  output logic                               last_of_run
);

  logic              req_valid, req_take;
  frwl_pkg::req_t    req;
  logic              res_push, res_full;
  frwl_pkg::result_t res, res_out;

  frwl_front u_front (
    .clk          (clk),
    .rst          (rst),
    .push         (push),
    .full         (full),
    .cmd          (cmd),
    .requester_id (requester_id),
    .req_valid    (req_valid),
    .req          (req),
    .req_take     (req_take)
  );

  frwl_engine #(
    .QUEUE_DEPTH (QUEUE_DEPTH),
    .MAX_READERS (MAX_READERS)
  ) u_engine (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req       (req),
    .req_take  (req_take),
    .res_push  (res_push),
    .res       (res),
    .res_full  (res_full)
  );

  frwl_out_fifo u_out (
    .clk   (clk),
    .rst   (rst),
    .push  (res_push),
    .din   (res),
    .full  (res_full),
    .pop   (pop),
    .dout  (res_out),
    .empty (empty)
  );

  assign status        = res_out.status;
  assign granted_id    = res_out.id;
  assign granted_write = res_out.write;
  assign last_of_run   = res_out.last;

endmodule
`default_nettype wire

// ----- test/fifo_fair_rw_lock_arbiter_tb.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// fifo_fair_rw_lock_arbiter_tb
// Self-checking bench for the fair FIFO reader/writer lock manager. Lock and
// unlock commands go in through the push/full side. A lock-state predictor
// works out the grants and rejections owed for every accepted command, and
// each result popped from the block is checked against the oldest one owed.
// Directed tests cover the special cases, then randomised traffic follows.
// ----------------------------------------------------------------------------
module fifo_fair_rw_lock_arbiter_tb;

  localparam int QDEPTH     = frwl_pkg::QUEUE_DEPTH_DEF;
  localparam int RD_LIMIT   = frwl_pkg::MAX_READERS_DEF;
  localparam int CYCLE_CAP  = 200000;
  localparam int DRAIN_WAIT = 12;
  localparam int RAND_ITEMS = 28;
  localparam int RAND_PHASE = 7;

  logic                          clk = 1'b0;
  logic                          rst = 1'b1;
  logic                          push = 1'b0;
  logic                          full;
  logic [frwl_pkg::CMD_W-1:0]    cmd = '0;
  logic [frwl_pkg::ID_W-1:0]     requester_id = '0;
  logic                          empty;
  logic                          pop = 1'b0;
  logic [frwl_pkg::STATUS_W-1:0] status;
  logic [frwl_pkg::ID_W-1:0]     granted_id;
  logic                          granted_write;
  logic                          last_of_run;

  // predicted lock state
  logic [4:0] lk_queue [QDEPTH];
  int         lk_count = 0;
  int         lk_head = 0;
  int         lk_readers = 0;
  bit         lk_writer = 1'b0;

  frwl_pkg::result_t owed_results [$];
  int         err_count = 0;
  int         cycle_count = 0;
  bit         tx_fast = 1'b0;
  bit         rx_fast = 1'b0;

  fifo_fair_rw_lock_arbiter i_dut (
    .clk           (clk),
    .rst           (rst),
    .push          (push),
    .full          (full),
    .cmd           (cmd),
    .requester_id  (requester_id),
    .empty         (empty),
    .pop           (pop),
    .status        (status),
    .granted_id    (granted_id),
    .granted_write (granted_write),
    .last_of_run   (last_of_run)
  );

  always #4 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
  end

  initial begin
    wait (cycle_count >= CYCLE_CAP);
    $display("fifo_fair_rw_lock_arbiter_tb NOT OK");
    $finish;
  end

  // Apply one command to the predicted lock state and queue up what it owes.
  function automatic void lock_mgr_step(input frwl_pkg::cmd_t c,
                                        input logic [frwl_pkg::ID_W-1:0] id);
    frwl_pkg::result_t batch [$];
    logic [4:0]        e;
    logic              wr;
    wr = c[0];
    case (c)
      frwl_pkg::CMD_LOCK_RD, frwl_pkg::CMD_LOCK_WR: begin
        if (lk_count >= QDEPTH) begin
          batch.push_back('{status: frwl_pkg::ST_FULL, id: id, write: wr, last: 1'b0});
        end else begin
          lk_queue[(lk_head + lk_count) % QDEPTH] = {wr, id};
          lk_count++;
        end
      end
      frwl_pkg::CMD_UNLOCK_RD: begin
        if (lk_readers == 0)
          batch.push_back('{status: frwl_pkg::ST_NO_HOLDER, id: id, write: 1'b0, last: 1'b0});
        else
          lk_readers--;
      end
      default: begin
        if (!lk_writer)
          batch.push_back('{status: frwl_pkg::ST_NO_HOLDER, id: id, write: 1'b1, last: 1'b0});
        else
          lk_writer = 1'b0;
      end
    endcase
    // release the head for as long as it is compatible, capped per command
    while (lk_count > 0 && batch.size() < frwl_pkg::MAX_RESULTS) begin
      e = lk_queue[lk_head];
      if (e[4]) begin
        if (lk_writer || lk_readers != 0) break;
        lk_writer = 1'b1;
      end else begin
        if (lk_writer || lk_readers >= RD_LIMIT) break;
        lk_readers++;
      end
      lk_head = (lk_head + 1) % QDEPTH;
      lk_count--;
      batch.push_back('{status: frwl_pkg::ST_GRANT, id: e[3:0], write: e[4], last: 1'b0});
    end
    if (batch.size() > 0) batch[batch.size() - 1].last = 1'b1;
    foreach (batch[i]) owed_results.push_back(batch[i]);
  endfunction

  // Push stays high after a transfer; the next call either keeps it or drops it.
  task automatic send_cmd(input frwl_pkg::cmd_t c, input logic [frwl_pkg::ID_W-1:0] id);
    int gap;
    gap = tx_fast ? 0 : $urandom_range(0, 9);
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    push         <= 1'b1;
    cmd          <= c;
    requester_id <= id;
    do @(negedge clk); while (full);
    @(posedge clk);
    lock_mgr_step(c, id);
  endtask

  task automatic settle();
    push <= 1'b0;
    while (owed_results.size() > 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
  endtask

  function automatic void check_field(input string name, input int exp_v, input int act_v);
    if (exp_v != act_v) begin
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, exp_v, act_v);
      err_count++;
    end
  endfunction

  // result side: sample at the falling edge, transfer at the next rising edge
  initial begin : result_checker
    int                gap;
    frwl_pkg::result_t exp_r;
    @(negedge rst);
    forever begin
      gap = rx_fast ? 0 : $urandom_range(0, 9);
      if (gap > 0) begin
        pop <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      pop <= 1'b1;
      do @(negedge clk); while (empty);
      if (owed_results.size() == 0) begin
        $display("%0t: unexpected result, expected none, got status %0d id %0d write %0d",
                 $time, status, granted_id, granted_write);
        err_count++;
      end else begin
        exp_r = owed_results.pop_front();
        check_field("status", exp_r.status, status);
        check_field("granted_id", exp_r.id, granted_id);
        check_field("granted_write", exp_r.write, granted_write);
        check_field("last_of_run", exp_r.last, last_of_run);
      end
      @(posedge clk);
    end
  end

  task automatic test_unlock_no_holder();
    send_cmd(frwl_pkg::CMD_UNLOCK_RD, 4'd0);
    send_cmd(frwl_pkg::CMD_UNLOCK_WR, 4'd15);
    send_cmd(frwl_pkg::CMD_UNLOCK_WR, 4'd0);
    send_cmd(frwl_pkg::CMD_UNLOCK_RD, 4'd15);
    settle();
  endtask

  // writer holds, readers pile up behind it plus a second writer
  task automatic test_reader_run();
    send_cmd(frwl_pkg::CMD_LOCK_WR, 4'd1);
    send_cmd(frwl_pkg::CMD_LOCK_RD, 4'd2);
    send_cmd(frwl_pkg::CMD_LOCK_RD, 4'd3);
    send_cmd(frwl_pkg::CMD_LOCK_RD, 4'd4);
    send_cmd(frwl_pkg::CMD_LOCK_WR, 4'd5);
    send_cmd(frwl_pkg::CMD_LOCK_RD, 4'd6);
    send_cmd(frwl_pkg::CMD_UNLOCK_WR, 4'd1);
    send_cmd(frwl_pkg::CMD_UNLOCK_RD, 4'd2);
    send_cmd(frwl_pkg::CMD_UNLOCK_RD, 4'd3);
    send_cmd(frwl_pkg::CMD_UNLOCK_RD, 4'd4);
    send_cmd(frwl_pkg::CMD_UNLOCK_WR, 4'd5);
    send_cmd(frwl_pkg::CMD_UNLOCK_RD, 4'd6);
    settle();
  endtask

  // fill the wait queue behind a writer, overflow it, then release all at once;
  // the released readers stay held into the next test
  task automatic test_queue_full();
    send_cmd(frwl_pkg::CMD_LOCK_WR, 4'd15);
    for (int i = 0; i < QDEPTH; i++) send_cmd(frwl_pkg::CMD_LOCK_RD, i[3:0]);
    send_cmd(frwl_pkg::CMD_LOCK_WR, 4'd9);
    send_cmd(frwl_pkg::CMD_LOCK_RD, 4'd0);
    rx_fast = 1'b0;
    send_cmd(frwl_pkg::CMD_UNLOCK_WR, 4'd15);
    settle();
  endtask

  // reader count saturates; the next reader and a writer wait for unlocks
  task automatic test_reader_limit();
    int n;
    n = 0;
    tx_fast = 1'b1;
    rx_fast = 1'b1;
    while (lk_readers < RD_LIMIT) begin
      send_cmd(frwl_pkg::CMD_LOCK_RD, n[3:0]);
      n++;
    end
    tx_fast = 1'b0;
    rx_fast = 1'b0;
    send_cmd(frwl_pkg::CMD_LOCK_RD, 4'd12);
    send_cmd(frwl_pkg::CMD_LOCK_WR, 4'd7);
    send_cmd(frwl_pkg::CMD_LOCK_RD, 4'd3);
    tx_fast = 1'b1;
    for (int i = 0; i < RD_LIMIT + 2; i++) send_cmd(frwl_pkg::CMD_UNLOCK_RD, i[3:0]);
    tx_fast = 1'b0;
    send_cmd(frwl_pkg::CMD_UNLOCK_WR, 4'd7);
    send_cmd(frwl_pkg::CMD_UNLOCK_RD, 4'd3);
    settle();
  endtask

  task automatic test_random_traffic();
    int             r;
    frwl_pkg::cmd_t c;
    for (int n = 0; n < RAND_ITEMS; n++) begin
      if (n % RAND_PHASE == 0) begin
        tx_fast = (n / RAND_PHASE) % 2 == 1;
        rx_fast = (n / RAND_PHASE) >= 2;
      end
      r = $urandom_range(0, 99);
      if (r < 22) c = frwl_pkg::CMD_LOCK_RD;
      else if (r < 40) c = frwl_pkg::CMD_LOCK_WR;
      else if (r < 68) c = (lk_readers > 0) ? frwl_pkg::CMD_UNLOCK_RD : frwl_pkg::CMD_LOCK_RD;
      else if (r < 88) c = lk_writer ? frwl_pkg::CMD_UNLOCK_WR : frwl_pkg::CMD_LOCK_WR;
      else c = frwl_pkg::cmd_t'($urandom_range(0, 3));
      send_cmd(c, 4'($urandom_range(0, 15)));
    end
    tx_fast = 1'b0;
    rx_fast = 1'b0;
    settle();
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    test_unlock_no_holder();
    test_reader_run();
    test_queue_full();
    test_reader_limit();
    test_random_traffic();
    if (err_count == 0)
      $display("fifo_fair_rw_lock_arbiter_tb OK");
    else
      $display("fifo_fair_rw_lock_arbiter_tb NOT OK");
    $finish;
  end

endmodule
`default_nettype wire
